/* rtl/core/cca_pkg.sv */
// Shared types and constants of the contiguous chunk allocator.
`timescale 1ns / 1ps

package cca_pkg;

	// bitmap row width
	localparam int WORD_BITS = 16;
	localparam int WB_W      = 4;

	// request fields
	localparam int OPCODE_W     = 2;
	localparam int OWNER_W      = 8;
	localparam int COUNT_W      = 11;
	localparam int DESC_FIELD_W = 7;
	localparam int OWNER_LSB    = OPCODE_W;
	localparam int COUNT_LSB    = OWNER_LSB + OWNER_W;
	localparam int DESC_LSB     = COUNT_LSB + COUNT_W;
	localparam int IN_TDATA_W   = 32;

	// result fields
	localparam int STATUS_W    = 3;
	localparam int GRANT_W     = 7;
	localparam int START_W     = 10;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOMEM   = 3'd1,
		ST_NODESC  = 3'd2,
		ST_OWNER   = 3'd3,
		ST_INVALID = 3'd4
	} status_t;

	// source of the next descriptor table index
	typedef enum logic [1:0] {
		DSEL_ANCHOR,
		DSEL_NEXT,
		DSEL_REQ,
		DSEL_ZERO
	} dsel_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_FIT,
		S_DS_START,
		S_DS,
		S_FREE_CHK,
		S_REL_CHK,
		S_REL_NEXT,
		S_WALK_RD,
		S_WALK_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load_req;
		logic    clr_step;
		logic    fit_init;
		logic    fit_step;
		logic    dsc_load;
		dsel_t   dsc_sel;
		logic    claim;
		logic    release_entry;
		logic    walk_rd;
		logic    walk_wr;
		logic    set_status;
		status_t status;
		logic    out_load;
	} cca_cmd_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] req_op;
		logic                own_zero;
		logic                count_zero;
		logic                count_big;
		logic                desc_bad;
		logic                clr_last;
		logic                fit_found;
		logic                fit_last;
		logic                dsc_free;
		logic                dsc_match;
		logic                dsc_last;
		logic                walk_last;
		logic                out_free;
	} cca_sts_t;

endpackage

/* rtl/core/cca_ctrl.sv */
// Request sequencer of the contiguous chunk allocator.
`timescale 1ns / 1ps

module cca_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  cca_pkg::cca_sts_t sts,
	output cca_pkg::cca_cmd_t cmd
);
	import cca_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.dsc_sel = DSEL_NEXT;
		cmd.status  = ST_OK;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_nx     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.own_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_INVALID;
					state_nx       = S_DONE;
				end else begin
					unique case (sts.req_op)
						OP_ALLOC: begin
							if (sts.count_zero) begin
								cmd.set_status = 1'b1;
								cmd.status     = ST_INVALID;
								state_nx       = S_DONE;
							end else if (sts.count_big) begin
								cmd.set_status = 1'b1;
								cmd.status     = ST_NOMEM;
								state_nx       = S_DONE;
							end else begin
								cmd.fit_init = 1'b1;
								state_nx     = S_FIT;
							end
						end
						OP_FREE: begin
							if (sts.desc_bad) begin
								cmd.set_status = 1'b1;
								cmd.status     = ST_INVALID;
								state_nx       = S_DONE;
							end else begin
								cmd.dsc_load = 1'b1;
								cmd.dsc_sel  = DSEL_REQ;
								state_nx     = S_FREE_CHK;
							end
						end
						OP_RELEASE: begin
							cmd.dsc_load = 1'b1;
							cmd.dsc_sel  = DSEL_ZERO;
							state_nx     = S_REL_CHK;
						end
						default: begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_INVALID;
							state_nx       = S_DONE;
						end
					endcase
				end
			end
			S_FIT: begin
				cmd.fit_step = 1'b1;
				if (sts.fit_found) begin
					state_nx = S_DS_START;
				end else if (sts.fit_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOMEM;
					state_nx       = S_DONE;
				end
			end
			S_DS_START: begin
				cmd.dsc_load = 1'b1;
				cmd.dsc_sel  = DSEL_ANCHOR;
				state_nx     = S_DS;
			end
			S_DS: begin
				if (sts.dsc_free) begin
					cmd.claim = 1'b1;
					state_nx  = S_WALK_RD;
				end else if (sts.dsc_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NODESC;
					state_nx       = S_DONE;
				end else begin
					cmd.dsc_load = 1'b1;
				end
			end
			S_FREE_CHK: begin
				if (sts.dsc_match) begin
					cmd.release_entry = 1'b1;
					state_nx          = S_WALK_RD;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_OWNER;
					state_nx       = S_DONE;
				end
			end
			S_REL_CHK: begin
				if (sts.dsc_match) begin
					cmd.release_entry = 1'b1;
					state_nx          = S_WALK_RD;
				end else if (sts.dsc_last) begin
					cmd.set_status = 1'b1;
					state_nx       = S_DONE;
				end else begin
					cmd.dsc_load = 1'b1;
				end
			end
			S_REL_NEXT: begin
				if (sts.dsc_last) begin
					cmd.set_status = 1'b1;
					state_nx       = S_DONE;
				end else begin
					cmd.dsc_load = 1'b1;
					state_nx     = S_REL_CHK;
				end
			end
			S_WALK_RD: begin
				cmd.walk_rd = 1'b1;
				state_nx    = S_WALK_WR;
			end
			S_WALK_WR: begin
				cmd.walk_wr = 1'b1;
				if (!sts.walk_last) begin
					state_nx = S_WALK_RD;
				end else if (sts.req_op == OP_RELEASE) begin
					state_nx = S_REL_NEXT;
				end else begin
					cmd.set_status = 1'b1;
					state_nx       = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/cca_datapath.sv */
// Bitmap, descriptor table, counters and result register of the allocator.
`timescale 1ns / 1ps

module cca_datapath #(
	parameter int CHUNKS      = 1024,
	parameter int DESCRIPTORS = 64,
	parameter int OWNER_BITS  = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [cca_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [cca_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  cca_pkg::cca_cmd_t                cmd,
	output cca_pkg::cca_sts_t                sts
);
	import cca_pkg::*;

	localparam int ROWS      = (CHUNKS + WORD_BITS - 1) / WORD_BITS;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int GW        = ROW_W + WB_W;
	localparam int AW        = GW + 1;
	localparam int CIDX_W    = $clog2(CHUNKS);
	localparam int CNT_W     = $clog2(CHUNKS + 1);
	localparam int DIDX_W    = $clog2(DESCRIPTORS);
	localparam int DESC_W    = OWNER_BITS + CIDX_W + CNT_W;
	localparam int OWN_EXT_W = (OWNER_BITS > OWNER_W) ? OWNER_BITS : OWNER_W;
	localparam int CMP_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int DW        = (DIDX_W + 1 > DESC_FIELD_W) ? DIDX_W + 1 : DESC_FIELD_W;
	localparam int SW        = CNT_W + WB_W + 1;
	localparam int CLR_N     = (ROWS > DESCRIPTORS) ? ROWS : DESCRIPTORS;
	localparam int CLR_W     = $clog2(CLR_N);

	// request registers
	logic [OPCODE_W-1:0]     op_q;
	logic [OWNER_BITS-1:0]   own_q;
	logic [COUNT_W-1:0]      count_q;
	logic [DESC_FIELD_W-1:0] desc_q;
	logic [OWN_EXT_W-1:0]    own_ext;
	logic [CMP_W-1:0]        count_ext;
	logic [CNT_W-1:0]        count_c;

	// memories
	logic [WORD_BITS-1:0] row_mem [ROWS];
	logic [WORD_BITS-1:0] row_rd_q;
	logic                 row_we, row_re;
	logic [ROW_W-1:0]     row_waddr, row_raddr;
	logic [WORD_BITS-1:0] row_wdata;

	logic [DESC_W-1:0]    dsc_mem [DESCRIPTORS];
	logic [DESC_W-1:0]    dsc_rd_q;
	logic                 dsc_we;
	logic [DIDX_W-1:0]    dsc_waddr;
	logic [DESC_W-1:0]    dsc_wdata;
	logic [OWNER_BITS-1:0] rd_owner;
	logic [CIDX_W-1:0]    rd_start;
	logic [CNT_W-1:0]     rd_len;

	// control state
	logic [CLR_W-1:0]  clr_q;
	logic [CNT_W-1:0]  freecnt_q;
	logic [DIDX_W-1:0] anchor_q;
	logic              out_valid_q;

	// scan and walk registers
	logic [ROW_W-1:0]  scan_row_q;
	logic [CNT_W-1:0]  run_q;
	logic [CIDX_W-1:0] fit_start_q;
	logic [DIDX_W-1:0] dsc_q, dsc_nx, dsc_inc;
	logic [DIDX_W-1:0] dcnt_q;
	logic [ROW_W-1:0]  walk_row_q, walk_end_q;
	logic [AW-1:0]     walk_lo_q, walk_hi_q;
	logic              walk_set_q;
	logic [WORD_BITS-1:0] walk_mask;
	logic [AW-1:0]     new_lo, new_hi, new_last;

	// first-fit search on the current row
	logic [WORD_BITS-1:0] fit_used, fit_sat;
	logic [WB_W-1:0]      fit_j;
	logic                 fit_found;
	logic [CNT_W-1:0]     fit_run_nx;
	logic [AW-1:0]        fit_start_w;

	// result and output registers
	status_t            res_status_q;
	logic [GRANT_W-1:0] res_gd_q;
	logic [START_W-1:0] res_start_q;
	status_t            out_status_q;
	logic [GRANT_W-1:0] out_gd_q;
	logic [START_W-1:0] out_start_q;

	assign own_ext   = OWN_EXT_W'(s_tdata[OWNER_LSB +: OWNER_W]);
	assign count_ext = CMP_W'(count_q);
	assign count_c   = CNT_W'(count_ext);

	assign rd_owner = dsc_rd_q[DESC_W-1 -: OWNER_BITS];
	assign rd_start = dsc_rd_q[CNT_W +: CIDX_W];
	assign rd_len   = dsc_rd_q[0 +: CNT_W];

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q    <= s_tdata[0 +: OPCODE_W];
			own_q   <= own_ext[OWNER_BITS-1:0];
			count_q <= s_tdata[COUNT_LSB +: COUNT_W];
			desc_q  <= s_tdata[DESC_LSB +: DESC_FIELD_W];
		end
	end

	// first-fit: run(j) is the free run ending at bit j, carried in from
	// earlier rows only while the row is free up to j
	always_comb begin
		int   last;
		logic any;
		logic [SW-1:0] cand;
		for (int b = 0; b < WORD_BITS; b++) begin
			fit_used[b] = row_rd_q[b]
				| (AW'({scan_row_q, WB_W'(b)}) >= AW'(CHUNKS));
		end
		fit_run_nx = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			any  = 1'b0;
			last = 0;
			for (int k = 0; k <= j; k++) begin
				if (fit_used[k]) begin
					any  = 1'b1;
					last = k;
				end
			end
			if (any) cand = SW'(j - last);
			else cand = SW'(run_q) + SW'(j + 1);
			fit_sat[j] = (cand >= SW'(count_c));
			if (j == WORD_BITS - 1) fit_run_nx = CNT_W'(cand);
		end
		fit_found = |fit_sat;
		fit_j     = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (fit_sat[j]) fit_j = WB_W'(j);
		end
	end

	assign fit_start_w = AW'({scan_row_q, fit_j}) + AW'(1) - AW'(count_c);

	// descriptor index selection
	assign dsc_inc = (dsc_q == DIDX_W'(DESCRIPTORS - 1)) ? '0 : dsc_q + 1'b1;

	always_comb begin
		unique case (cmd.dsc_sel)
			DSEL_ANCHOR: dsc_nx = anchor_q;
			DSEL_NEXT:   dsc_nx = dsc_inc;
			DSEL_REQ:    dsc_nx = DIDX_W'(desc_q - 1'b1);
			DSEL_ZERO:   dsc_nx = '0;
			default:     dsc_nx = '0;
		endcase
	end

	// walk range set up by a claim or a release
	always_comb begin
		if (cmd.claim) begin
			new_lo = AW'(fit_start_q);
			new_hi = AW'(fit_start_q) + AW'(count_c);
		end else begin
			new_lo = AW'(rd_start);
			new_hi = AW'(rd_start) + AW'(rd_len);
		end
		new_last = new_hi - AW'(1);
	end

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			walk_mask[b] = (AW'({walk_row_q, WB_W'(b)}) >= walk_lo_q)
				&& (AW'({walk_row_q, WB_W'(b)}) < walk_hi_q);
		end
	end

	// bitmap ports
	always_comb begin
		row_we    = 1'b0;
		row_waddr = walk_row_q;
		row_wdata = walk_set_q ? (row_rd_q | walk_mask) : (row_rd_q & ~walk_mask);
		if (cmd.clr_step) begin
			row_we    = (clr_q < CLR_W'(ROWS - 1)) || (clr_q == CLR_W'(ROWS - 1));
			row_waddr = clr_q[ROW_W-1:0];
			row_wdata = '0;
		end else if (cmd.walk_wr) begin
			row_we = 1'b1;
		end
		row_re    = cmd.fit_init | cmd.fit_step | cmd.walk_rd;
		row_raddr = walk_row_q;
		if (cmd.fit_init) row_raddr = '0;
		else if (cmd.fit_step) row_raddr = scan_row_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (row_we) row_mem[row_waddr] <= row_wdata;
		if (row_re) row_rd_q <= row_mem[row_raddr];
	end

	// descriptor table ports
	always_comb begin
		dsc_we    = 1'b0;
		dsc_waddr = dsc_q;
		dsc_wdata = {OWNER_BITS'(0), rd_start, rd_len};
		if (cmd.clr_step) begin
			dsc_we    = (clr_q < CLR_W'(DESCRIPTORS - 1)) || (clr_q == CLR_W'(DESCRIPTORS - 1));
			dsc_waddr = clr_q[DIDX_W-1:0];
			dsc_wdata = '0;
		end else if (cmd.claim) begin
			dsc_we    = 1'b1;
			dsc_wdata = {own_q, fit_start_q, count_c};
		end else if (cmd.release_entry) begin
			dsc_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dsc_we) dsc_mem[dsc_waddr] <= dsc_wdata;
		if (cmd.dsc_load) dsc_rd_q <= dsc_mem[dsc_nx];
	end

	// scan, walk and result registers
	always_ff @(posedge clk) begin
		if (cmd.fit_init) begin
			scan_row_q <= '0;
			run_q      <= '0;
		end else if (cmd.fit_step) begin
			scan_row_q <= scan_row_q + 1'b1;
			run_q      <= fit_run_nx;
			if (fit_found) fit_start_q <= CIDX_W'(fit_start_w);
		end
		if (cmd.dsc_load) begin
			dsc_q  <= dsc_nx;
			dcnt_q <= (cmd.dsc_sel == DSEL_NEXT) ? dcnt_q + 1'b1 : '0;
		end
		if (cmd.claim || cmd.release_entry) begin
			walk_lo_q  <= new_lo;
			walk_hi_q  <= new_hi;
			walk_row_q <= new_lo[GW-1:WB_W];
			walk_end_q <= new_last[GW-1:WB_W];
			walk_set_q <= cmd.claim;
		end else if (cmd.walk_wr) begin
			walk_row_q <= walk_row_q + 1'b1;
		end
		if (cmd.load_req) begin
			res_gd_q    <= '0;
			res_start_q <= '0;
		end else if (cmd.claim) begin
			res_gd_q    <= GRANT_W'({1'b0, dsc_q} + 1'b1);
			res_start_q <= START_W'(fit_start_q);
		end
		if (cmd.set_status) res_status_q <= cmd.status;
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_gd_q     <= (res_status_q == ST_OK) ? res_gd_q : '0;
			out_start_q  <= (res_status_q == ST_OK) ? res_start_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			freecnt_q   <= CNT_W'(CHUNKS);
			anchor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.claim) begin
				freecnt_q <= freecnt_q - count_c;
				anchor_q  <= dsc_inc;
			end else if (cmd.release_entry) begin
				freecnt_q <= freecnt_q + rd_len;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_start_q, out_gd_q, out_status_q});

	assign sts.req_op     = op_q;
	assign sts.own_zero   = (own_q == '0);
	assign sts.count_zero = (count_q == '0);
	assign sts.count_big  = (count_ext > CMP_W'(freecnt_q));
	assign sts.desc_bad   = (desc_q == '0) || (DW'(desc_q) > DW'(DESCRIPTORS));
	assign sts.clr_last   = (clr_q == CLR_W'(CLR_N - 1));
	assign sts.fit_found  = fit_found;
	assign sts.fit_last   = (scan_row_q == ROW_W'(ROWS - 1));
	assign sts.dsc_free   = (rd_owner == '0);
	assign sts.dsc_match  = (rd_owner == own_q);
	assign sts.dsc_last   = (dcnt_q == DIDX_W'(DESCRIPTORS - 1));
	assign sts.walk_last  = (walk_row_q == walk_end_q);
	assign sts.out_free   = !out_valid_q || m_tready;

endmodule

/* rtl/core/contiguous_chunk_allocator_core.sv */
// Top level of the contiguous chunk allocator: sequencer, datapath, checks.
`timescale 1ns / 1ps

// Keeps a bitmap of CHUNKS chunks in rows of 16 and a table of DESCRIPTORS
// descriptors (owner, start, length). Requests are handled one at a time;
// one result per request goes to an output register, so the next request
// is taken while a result waits. After reset a clearing pass zeroes every
// bitmap row and every descriptor before the first request. An allocate
// scans the bitmap rows for the first fit, visits descriptors from the
// rotating anchor until it finds a free one and then marks the bitmap rows
// of the run. A free checks the owner of its descriptor and clears the
// bitmap rows of its run. A release visits every descriptor in the table
// and clears the bitmap rows of each one that its owner holds. A request
// rejected at decode goes straight to its result. A result not yet taken
// holds the sequencer in its last state. Everything runs through the bitmap
// read and write ports, one row at a time, and the descriptor table ports,
// one entry at a time.
module contiguous_chunk_allocator_core #(
	parameter int CHUNKS      = 1024,
	parameter int DESCRIPTORS = 64,
	parameter int OWNER_BITS  = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// opcode[1:0], owner[9:2], chunk_count[20:10], descriptor[27:21]
	input  logic [cca_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status[2:0], granted_descriptor[9:3], start_chunk[19:10]
	output logic [cca_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import cca_pkg::*;

	cca_cmd_t cmd;
	cca_sts_t sts;

	cca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cca_datapath #(
		.CHUNKS      (CHUNKS),
		.DESCRIPTORS (DESCRIPTORS),
		.OWNER_BITS  (OWNER_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	// one request in flight at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in progress");

	// result register is never overwritten while it still holds a result
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result overwritten before it was taken");

	// a claimed descriptor is always followed by marking its chunks
	a_claim_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.claim |=> cmd.walk_rd)
		else $error("claim not followed by a bitmap update");

	// only a successful request carries a descriptor or a start chunk
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK)
			|-> (m_tdata[STATUS_W +: GRANT_W + START_W] == '0))
		else $error("failed request returned a grant");

endmodule
